### rtl/ieae_pkg.sv
// shared types and constants for the infix expression evaluator
package ieae_pkg;

    localparam int unsigned DATA_W = 32;
    localparam int unsigned CHAR_W = 8;
    localparam int unsigned CNT_W  = $clog2(DATA_W);

    // formula characters
    localparam logic [CHAR_W-1:0] CH_ADD  = 8'h2B;
    localparam logic [CHAR_W-1:0] CH_SUB  = 8'h2D;
    localparam logic [CHAR_W-1:0] CH_MUL  = 8'h2A;
    localparam logic [CHAR_W-1:0] CH_DIV  = 8'h2F;
    localparam logic [CHAR_W-1:0] CH_ZERO = 8'h30;
    localparam logic [CHAR_W-1:0] CH_NINE = 8'h39;

    // operator waiting to join the next number to the term
    typedef enum logic [1:0] {
        TP_NONE,
        TP_MUL,
        TP_DIV
    } term_op_t;

    // operator character held while an item is worked on
    typedef enum logic [1:0] {
        K_MUL,
        K_DIV,
        K_ADD,
        K_SUB
    } op_kind_t;

    // main sequencer
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_CLOSE,
        ST_WAIT,
        ST_AFTER,
        ST_TERM,
        ST_OUT
    } state_t;

    // serial multiply / divide unit
    typedef enum logic [1:0] {
        MD_IDLE,
        MD_RUN,
        MD_FIX
    } md_state_t;

    typedef struct packed {
        logic start;
        logic is_div;
    } md_req_t;

    typedef struct packed {
        logic              done;
        logic [DATA_W-1:0] result;
    } md_resp_t;

endpackage

### rtl/ieae_if.sv
// handshake channels for formula characters and results
interface ieae_char_if;
    logic       valid;
    logic       ready;
    logic [7:0] char_code;
    logic       last_char;

    modport source (output valid, output char_code, output last_char, input ready);
    modport sink (input valid, input char_code, input last_char, output ready);
endinterface

interface ieae_result_if;
    logic        valid;
    logic        ready;
    logic [31:0] value;
    logic        div_by_zero;
    logic        bad_char;

    modport source (output valid, output value, output div_by_zero, output bad_char,
                    input ready);
    modport sink (input valid, input value, input div_by_zero, input bad_char,
                  output ready);
endinterface

### rtl/ieae_muldiv.sv
// shared bit-serial multiplier and signed restoring divider
module ieae_muldiv (
    input  logic                     clk,
    input  logic                     rst_n,
    input  ieae_pkg::md_req_t        req,
    input  logic [ieae_pkg::DATA_W-1:0] a,
    input  logic [ieae_pkg::DATA_W-1:0] b,
    output ieae_pkg::md_resp_t       resp
);
    import ieae_pkg::*;

    md_state_t         state_reg, state_next;
    logic [CNT_W-1:0]  cnt_reg, cnt_next;
    logic [DATA_W-1:0] acc_reg, acc_next;
    logic [DATA_W-1:0] sh_reg, sh_next;
    logic [DATA_W-1:0] dv_reg, dv_next;
    logic              div_reg, div_next;
    logic              neg_reg, neg_next;

    logic [DATA_W:0]   rem_sh;
    logic [DATA_W:0]   trial;
    logic [DATA_W-1:0] add_sum;

    // one restoring step and one shift-add step
    assign rem_sh  = {acc_reg, sh_reg[DATA_W-1]};
    assign trial   = rem_sh - {1'b0, dv_reg};
    assign add_sum = acc_reg + dv_reg;

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            MD_IDLE: if (req.start) state_next = MD_RUN;
            MD_RUN:  if (cnt_reg == CNT_W'(DATA_W - 1)) state_next = MD_FIX;
            MD_FIX:  state_next = MD_IDLE;
            default: state_next = MD_IDLE;
        endcase
    end

    // datapath
    always_comb
    begin
        cnt_next = cnt_reg;
        acc_next = acc_reg;
        sh_next  = sh_reg;
        dv_next  = dv_reg;
        div_next = div_reg;
        neg_next = neg_reg;
        case (state_reg)
            MD_IDLE:
            begin
                if (req.start)
                begin
                    cnt_next = '0;
                    acc_next = '0;
                    div_next = req.is_div;
                    neg_next = a[DATA_W-1] ^ b[DATA_W-1];
                    if (req.is_div)
                    begin
                        sh_next = a[DATA_W-1] ? (~a + 1'b1) : a;
                        dv_next = b[DATA_W-1] ? (~b + 1'b1) : b;
                    end
                    else
                    begin
                        sh_next = b;
                        dv_next = a;
                    end
                end
            end
            MD_RUN:
            begin
                cnt_next = cnt_reg + 1'b1;
                if (div_reg)
                begin
                    if (!trial[DATA_W])
                    begin
                        acc_next = trial[DATA_W-1:0];
                        sh_next  = {sh_reg[DATA_W-2:0], 1'b1};
                    end
                    else
                    begin
                        acc_next = rem_sh[DATA_W-1:0];
                        sh_next  = {sh_reg[DATA_W-2:0], 1'b0};
                    end
                end
                else
                begin
                    if (sh_reg[0])
                        acc_next = add_sum;
                    sh_next = {1'b0, sh_reg[DATA_W-1:1]};
                    dv_next = {dv_reg[DATA_W-2:0], 1'b0};
                end
            end
            default:
            begin
            end
        endcase
    end

    // result with sign fix for the quotient
    always_comb
    begin
        resp.done   = (state_reg == MD_FIX);
        resp.result = acc_reg;
        if (div_reg)
            resp.result = neg_reg ? (~sh_reg + 1'b1) : sh_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= MD_IDLE;
            cnt_reg   <= '0;
            div_reg   <= 1'b0;
            neg_reg   <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
            div_reg   <= div_next;
            neg_reg   <= neg_next;
        end
    end

    always_ff @(posedge clk)
    begin
        acc_reg <= acc_next;
        sh_reg  <= sh_next;
        dv_reg  <= dv_next;
    end

endmodule

### rtl/infix_arith_expression_evaluator.sv
// top level: infix formula evaluator, one ascii character per item
//
//  channel  dir  payload                          handshake
//  formula  in   char_code[7:0], last_char        valid / ready
//  result   out  value[31:0], div_by_zero,        valid / ready
//                bad_char
//
// a digit or unknown character leaves the sequencer idle; an operator
// closes the number (ST_CLOSE, ST_AFTER, and ST_TERM for + or -); joining
// a number by * or / runs the shared bit-serial unit in ST_WAIT; the last
// character also closes the term (a last * or / closes the number twice) and
// ST_OUT loads the result; formula is taken only while the sequencer is idle
// the result register holds an item while the next formula is read in
// reset spares result data; a result stalls only the next formula's closing
module infix_arith_expression_evaluator (
    input  logic          clk,
    input  logic          rst_n,
    ieae_char_if.sink     formula,
    ieae_result_if.source result
);
    import ieae_pkg::*;

    state_t            state_reg, state_next;
    logic [DATA_W-1:0] number_reg, number_next;
    logic [DATA_W-1:0] term_reg, term_next;
    term_op_t          pend_reg, pend_next;
    logic [DATA_W-1:0] sum_reg, sum_next;
    logic              sub_reg, sub_next;
    logic              dz_reg, dz_next;
    logic              bad_reg, bad_next;
    logic              final_reg, final_next;
    logic              last_reg, last_next;
    op_kind_t          kind_reg, kind_next;
    logic              out_valid_reg, out_valid_next;
    logic [DATA_W-1:0] out_value_reg;
    logic              out_dz_reg;
    logic              out_bad_reg;

    logic              accept;
    logic              is_digit;
    logic              is_op;
    logic              kind_term;
    logic              out_load;
    logic              unit_needed;
    op_kind_t          char_kind;
    md_req_t           md_req;
    md_resp_t          md_resp;

    // input decode
    assign formula.ready = (state_reg == ST_IDLE);
    assign accept        = formula.valid && formula.ready;
    assign is_digit      = formula.char_code inside {[CH_ZERO:CH_NINE]};
    assign is_op         = formula.char_code inside {CH_ADD, CH_SUB, CH_MUL, CH_DIV};

    always_comb
    begin
        case (formula.char_code)
            CH_MUL:  char_kind = K_MUL;
            CH_DIV:  char_kind = K_DIV;
            CH_SUB:  char_kind = K_SUB;
            default: char_kind = K_ADD;
        endcase
    end

    assign kind_term   = (kind_reg == K_MUL) || (kind_reg == K_DIV);
    assign unit_needed = (pend_reg == TP_MUL) ||
                         ((pend_reg == TP_DIV) && (number_reg != '0));
    assign out_load    = (state_reg == ST_OUT) && (!out_valid_reg || result.ready);

    // shared serial multiply / divide
    ieae_muldiv u_muldiv (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (md_req),
        .a     (term_reg),
        .b     (number_reg),
        .resp  (md_resp)
    );

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
                if (accept && (is_op || formula.last_char))
                    state_next = ST_CLOSE;
            ST_CLOSE:
                state_next = unit_needed ? ST_WAIT : ST_AFTER;
            ST_WAIT:
                if (md_resp.done)
                    state_next = ST_AFTER;
            ST_AFTER:
                if (!final_reg && kind_term)
                    state_next = last_reg ? ST_CLOSE : ST_IDLE;
                else
                    state_next = ST_TERM;
            ST_TERM:
                if (final_reg)
                    state_next = ST_OUT;
                else
                    state_next = last_reg ? ST_CLOSE : ST_IDLE;
            ST_OUT:
                if (out_load)
                    state_next = ST_IDLE;
            default:
                state_next = ST_IDLE;
        endcase
    end

    // datapath and outputs
    always_comb
    begin
        number_next = number_reg;
        term_next   = term_reg;
        pend_next   = pend_reg;
        sum_next    = sum_reg;
        sub_next    = sub_reg;
        dz_next     = dz_reg;
        bad_next    = bad_reg;
        final_next  = final_reg;
        last_next   = last_reg;
        kind_next   = kind_reg;
        md_req      = '0;
        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    last_next = formula.last_char;
                    if (is_digit)
                        number_next = {number_reg[DATA_W-4:0], 3'b000}
                                    + {number_reg[DATA_W-2:0], 1'b0}
                                    + {{(DATA_W-4){1'b0}}, formula.char_code[3:0]};
                    else if (!is_op)
                        bad_next = 1'b1;
                    if (is_op)
                    begin
                        kind_next  = char_kind;
                        final_next = 1'b0;
                    end
                    else
                        final_next = 1'b1;
                end
            end
            ST_CLOSE:
            begin
                // join the finished number to the term
                case (pend_reg)
                    TP_MUL:
                    begin
                        md_req.start  = 1'b1;
                        md_req.is_div = 1'b0;
                    end
                    TP_DIV:
                    begin
                        if (number_reg == '0)
                        begin
                            term_next = '0;
                            dz_next   = 1'b1;
                        end
                        else
                        begin
                            md_req.start  = 1'b1;
                            md_req.is_div = 1'b1;
                        end
                    end
                    default:
                        term_next = number_reg;
                endcase
                if (!unit_needed)
                    number_next = '0;
            end
            ST_WAIT:
            begin
                if (md_resp.done)
                begin
                    term_next   = md_resp.result;
                    number_next = '0;
                end
            end
            ST_AFTER:
            begin
                if (!final_reg && kind_term)
                begin
                    pend_next = (kind_reg == K_MUL) ? TP_MUL : TP_DIV;
                    if (last_reg)
                        final_next = 1'b1;
                end
            end
            ST_TERM:
            begin
                // join the finished term to the sum
                sum_next  = sub_reg ? (sum_reg - term_reg) : (sum_reg + term_reg);
                term_next = '0;
                pend_next = TP_NONE;
                if (!final_reg)
                begin
                    sub_next = (kind_reg == K_SUB);
                    if (last_reg)
                        final_next = 1'b1;
                end
            end
            ST_OUT:
            begin
                if (out_load)
                begin
                    number_next = '0;
                    term_next   = '0;
                    pend_next   = TP_NONE;
                    sum_next    = '0;
                    sub_next    = 1'b0;
                    dz_next     = 1'b0;
                    bad_next    = 1'b0;
                    final_next  = 1'b0;
                end
            end
            default:
            begin
            end
        endcase
    end

    // result register
    assign out_valid_next     = (out_valid_reg && !result.ready) || out_load;
    assign result.valid       = out_valid_reg;
    assign result.value       = out_value_reg;
    assign result.div_by_zero = out_dz_reg;
    assign result.bad_char    = out_bad_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            number_reg    <= '0;
            term_reg      <= '0;
            pend_reg      <= TP_NONE;
            sum_reg       <= '0;
            sub_reg       <= 1'b0;
            dz_reg        <= 1'b0;
            bad_reg       <= 1'b0;
            final_reg     <= 1'b0;
            last_reg      <= 1'b0;
            kind_reg      <= K_ADD;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            number_reg    <= number_next;
            term_reg      <= term_next;
            pend_reg      <= pend_next;
            sum_reg       <= sum_next;
            sub_reg       <= sub_next;
            dz_reg        <= dz_next;
            bad_reg       <= bad_next;
            final_reg     <= final_next;
            last_reg      <= last_next;
            kind_reg      <= kind_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (out_load)
        begin
            out_value_reg <= sum_reg;
            out_dz_reg    <= dz_reg;
            out_bad_reg   <= bad_reg;
        end
    end

endmodule

### rtl/ieae_chk.sv
// port-level checks for the infix expression evaluator, bound to the top level
module ieae_chk (
    input logic        clk,
    input logic        rst_n,
    input logic        in_valid,
    input logic        in_ready,
    input logic [7:0]  char_code,
    input logic        last_char,
    input logic        out_valid,
    input logic        out_ready,
    input logic [31:0] value,
    input logic        div_by_zero,
    input logic        bad_char
);
    import ieae_pkg::*;

    logic is_op;

    assign is_op = (char_code == CH_ADD) || (char_code == CH_SUB) ||
                   (char_code == CH_MUL) || (char_code == CH_DIV);

    // a stalled result item stays offered
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid)
        else $error("result item dropped while stalled");

    // a stalled result item keeps its payload
    a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> $stable(value) && $stable(div_by_zero) &&
                                    $stable(bad_char))
        else $error("result payload changed while stalled");

    // a digit or unknown character in mid formula leaves the formula channel ready
    a_digit_fast: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready && !last_char && !is_op |=> in_ready)
        else $error("formula not ready after a plain character");

    // the last character starts closing the formula
    a_last_busy: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready && last_char |=> !in_ready)
        else $error("formula ready right after its last character");

endmodule

bind infix_arith_expression_evaluator ieae_chk u_ieae_chk (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (formula.valid),
    .in_ready    (formula.ready),
    .char_code   (formula.char_code),
    .last_char   (formula.last_char),
    .out_valid   (result.valid),
    .out_ready   (result.ready),
    .value       (result.value),
    .div_by_zero (result.div_by_zero),
    .bad_char    (result.bad_char)
);

### bench/tb.sv
// self-checking bench for the infix formula evaluator: directed table, then random formulas
`timescale 1ns / 1ps

module tb;
    import ieae_pkg::*;

    // one evaluated formula
    typedef struct packed {
        logic [DATA_W-1:0] value;
        logic              div_by_zero;
        logic              bad_char;
    } outcome_t;

    // directed row: packed like a string literal, first character in the highest of its len bytes
    typedef struct {
        logic [63:0] text;
        int          len;
        bit          typed;
        outcome_t    outcome;
    } formula_row_t;

    localparam int N_ROWS = 8;
    localparam int RANDOM_CHARS = 1950;

    formula_row_t formula_table [N_ROWS] = '{
        '{"7",        1, 1'b1, '{32'd7,         1'b0, 1'b0}},
        '{"+",        1, 1'b1, '{32'd0,         1'b0, 1'b0}},
        '{"8-9",      3, 1'b1, '{32'hFFFF_FFFF, 1'b0, 1'b0}},
        '{"6*7/0",    5, 1'b1, '{32'd0,         1'b1, 1'b0}},
        '{64'hFF,     1, 1'b1, '{32'd0,         1'b0, 1'b1}},
        '{64'h00_35,  2, 1'b1, '{32'd5,         1'b0, 1'b1}},
        '{"2+3*4",    5, 1'b0, '{32'd0,         1'b0, 1'b0}},
        '{"9/2-1",    5, 1'b0, '{32'd0,         1'b0, 1'b0}}
    };

    logic clk;
    logic rst_n;

    ieae_char_if   formula_ch ();
    ieae_result_if result_ch ();

    infix_arith_expression_evaluator DUT (
        .clk     (clk),
        .rst_n   (rst_n),
        .formula (formula_ch),
        .result  (result_ch)
    );

    // evaluator state mirrored by the bench
    logic [DATA_W-1:0] number_reg;
    logic [DATA_W-1:0] term_reg;
    term_op_t          term_join;
    logic [DATA_W-1:0] sum_reg;
    logic              sum_subtract;
    logic              saw_div_zero;
    logic              saw_bad_char;

    outcome_t pending_outcomes [$];
    outcome_t want;
    int errors;
    int formulas_seen;
    int chars_sent;
    int src_idle_pct;
    int snk_stall_pct;

    // clock
    initial clk = 1'b0;
    always #5 clk = ~clk;

    // hard limit on run length
    initial
    begin
        #10_000_000;
        $display("tb: errors");
        $finish;
    end

    // clear mirrored formula state
    task automatic clear_formula();
        number_reg   = '0;
        term_reg     = '0;
        term_join    = TP_NONE;
        sum_reg      = '0;
        sum_subtract = 1'b0;
        saw_div_zero = 1'b0;
        saw_bad_char = 1'b0;
    endtask

    // join the finished number to the current term
    task automatic join_number();
        longint quotient;
        case (term_join)
            TP_MUL: term_reg = term_reg * number_reg;
            TP_DIV:
            begin
                if (number_reg == '0)
                begin
                    term_reg     = '0;
                    saw_div_zero = 1'b1;
                end
                else
                begin
                    quotient = longint'($signed(term_reg)) / longint'($signed(number_reg));
                    term_reg = quotient[DATA_W-1:0];
                end
            end
            default: term_reg = number_reg;
        endcase
        number_reg = '0;
    endtask

    // join the finished term to the sum
    task automatic join_term();
        if (sum_subtract)
            sum_reg = sum_reg - term_reg;
        else
            sum_reg = sum_reg + term_reg;
        term_reg  = '0;
        term_join = TP_NONE;
    endtask

    // fold one character into the formula; closes it on the last character
    task automatic evaluate_char(input logic [7:0] ch, input logic last, output bit closed,
                                 output outcome_t outcome);
        closed  = 1'b0;
        outcome = '0;
        if (ch >= CH_ZERO && ch <= CH_NINE)
            number_reg = number_reg * 32'd10 + DATA_W'(ch - CH_ZERO);
        else if (ch == CH_MUL || ch == CH_DIV)
        begin
            join_number();
            term_join = (ch == CH_MUL) ? TP_MUL : TP_DIV;
        end
        else if (ch == CH_ADD || ch == CH_SUB)
        begin
            join_number();
            join_term();
            sum_subtract = (ch == CH_SUB);
        end
        else
            saw_bad_char = 1'b1;

        if (last)
        begin
            join_number();
            join_term();
            closed  = 1'b1;
            outcome = '{sum_reg, saw_div_zero, saw_bad_char};
            clear_formula();
        end
    endtask

    // offer one character, wait for it to be taken, then record what it should yield
    task automatic send_char(input logic [7:0] ch, input logic last, input bit typed,
                             input outcome_t typed_outcome);
        bit closed;
        outcome_t predicted;
        while ($urandom_range(99) < src_idle_pct)
        begin
            formula_ch.valid <= 1'b0;
            @(posedge clk);
        end
        formula_ch.valid     <= 1'b1;
        formula_ch.char_code <= ch;
        formula_ch.last_char <= last;
        do
            @(posedge clk);
        while (!formula_ch.ready);
        chars_sent++;
        evaluate_char(ch, last, closed, predicted);
        if (closed)
            pending_outcomes.insert(pending_outcomes.size(),
                                    typed ? typed_outcome : predicted);
    endtask

    // hold the formula channel quiet until every result is back
    task automatic drain();
        formula_ch.valid <= 1'b0;
        while (pending_outcomes.size() != 0)
            @(posedge clk);
    endtask

    function automatic logic [7:0] pick_op();
        case ($urandom_range(3))
            0: return CH_ADD;
            1: return CH_SUB;
            2: return CH_MUL;
            default: return CH_DIV;
        endcase
    endfunction

    // random formulas: mostly well formed, some edge patterns, some noise
    task automatic run_random(input int quota);
        logic [7:0] text [$];
        string min_by_minus_one;
        int sent;
        int kind;
        int terms;
        int pick;
        int ndig;
        int nchar;
        sent = 0;
        min_by_minus_one = "2147483648/4294967295";
        while (sent < quota)
        begin
            text.delete();
            kind = $urandom_range(99);
            if (kind < 6)
            begin
                // most negative value divided by all-ones pattern
                for (int i = 0; i < min_by_minus_one.len(); i++)
                    text.insert(text.size(), min_by_minus_one[i]);
            end
            else if (kind < 85)
            begin
                if ($urandom_range(9) == 0)
                    text.insert(text.size(), pick_op());
                terms = $urandom_range(1, 6);
                for (int t = 0; t < terms; t++)
                begin
                    if (t > 0)
                        text.insert(text.size(), pick_op());
                    pick = $urandom_range(99);
                    if (pick < 8)
                        ndig = 0;
                    else if (pick < 18)
                        ndig = $urandom_range(10, 12);
                    else if (pick < 28)
                    begin
                        text.insert(text.size(), CH_ZERO);
                        ndig = 0;
                    end
                    else
                        ndig = $urandom_range(1, 3);
                    for (int d = 0; d < ndig; d++)
                        text.insert(text.size(), CH_ZERO + 8'($urandom_range(9)));
                    if ($urandom_range(19) == 0)
                        text.insert(text.size(), 8'($urandom_range(255)));
                end
                if ($urandom_range(9) == 0)
                    text.insert(text.size(), pick_op());
            end
            else
            begin
                // noise: arbitrary bytes mixed with digits and operators
                nchar = $urandom_range(1, 8);
                for (int k = 0; k < nchar; k++)
                begin
                    pick = $urandom_range(99);
                    if (pick < 40)
                        text.insert(text.size(), 8'($urandom_range(255)));
                    else if (pick < 70)
                        text.insert(text.size(), CH_ZERO + 8'($urandom_range(9)));
                    else
                        text.insert(text.size(), pick_op());
                end
            end
            foreach (text[i])
                send_char(text[i], i == text.size() - 1, 1'b0, '0);
            sent += text.size();
        end
    endtask

    // result side: random stall, compare against oldest expectation
    always @(posedge clk)
    begin
        if (rst_n && result_ch.valid && result_ch.ready)
        begin
            formulas_seen++;
            if (pending_outcomes.size() == 0)
            begin
                $display("%0t: unexpected result value %h div_by_zero %b bad_char %b",
                         $time, result_ch.value, result_ch.div_by_zero, result_ch.bad_char);
                errors++;
            end
            else
            begin
                want = pending_outcomes.pop_front();
                if (result_ch.value !== want.value)
                begin
                    $display("%0t: value expected %h got %h", $time, want.value,
                             result_ch.value);
                    errors++;
                end
                if (result_ch.div_by_zero !== want.div_by_zero)
                begin
                    $display("%0t: div_by_zero expected %b got %b", $time,
                             want.div_by_zero, result_ch.div_by_zero);
                    errors++;
                end
                if (result_ch.bad_char !== want.bad_char)
                begin
                    $display("%0t: bad_char expected %b got %b", $time, want.bad_char,
                             result_ch.bad_char);
                    errors++;
                end
            end
        end
        result_ch.ready <= ($urandom_range(99) >= snk_stall_pct);
    end

    // main sequence
    initial
    begin
        errors        = 0;
        formulas_seen = 0;
        chars_sent    = 0;
        src_idle_pct  = 0;
        snk_stall_pct = 0;
        clear_formula();
        formula_ch.valid     = 1'b0;
        formula_ch.char_code = '0;
        formula_ch.last_char = 1'b0;
        result_ch.ready      = 1'b0;
        rst_n                = 1'b0;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed formulas, no idling
        foreach (formula_table[r])
            for (int i = 0; i < formula_table[r].len; i++)
                send_char(formula_table[r].text[8 * (formula_table[r].len - 1 - i) +: 8],
                          i == formula_table[r].len - 1, formula_table[r].typed,
                          formula_table[r].outcome);
        drain();

        // random formulas under each idling pattern
        for (int phase = 0; phase < 4; phase++)
        begin
            case (phase)
                0: begin src_idle_pct = 0;  snk_stall_pct = 0;  end
                1: begin src_idle_pct = 82; snk_stall_pct = 0;  end
                2: begin src_idle_pct = 0;  snk_stall_pct = 82; end
                default: begin src_idle_pct = 33; snk_stall_pct = 33; end
            endcase
            run_random(RANDOM_CHARS / 4);
            drain();
        end

        repeat (100) @(posedge clk);
        if (pending_outcomes.size() != 0)
        begin
            $display("%0t: %0d results never arrived", $time, pending_outcomes.size());
            errors++;
        end
        $display("tb: %0d characters sent, %0d formulas checked", chars_sent, formulas_seen);
        $display("tb: phases ran with no idling, sender gaps, receiver stalls and both");
        if (errors == 0)
            $display("tb: clean");
        else
            $display("tb: errors");
        $finish;
    end

endmodule
